// ===== rtl/core/lwfd_pkg.sv =====
// Shared types and constants of the lock wait-for deadlock detector
`default_nettype none
package lwfd_pkg;

  localparam int ID_W     = 16;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_REQUEST  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ACQUIRE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REGISTER = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CHECK    = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OWNER_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_VERT_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OSCAN,
    ST_ODEC,
    ST_VSCAN,
    ST_VADD1,
    ST_VADD2,
    ST_ROWRD,
    ST_ROWWR,
    ST_OWRITE,
    ST_COPY,
    ST_KRD,
    ST_KPASS,
    ST_FSCAN,
    ST_VRD,
    ST_VWR,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/lwfd_if.sv =====
// Request and response channel interfaces of the deadlock detector
`default_nettype none
interface lwfd_req_if;
  logic                        valid;
  logic                        ready;
  logic [lwfd_pkg::MODE_W-1:0] mode;
  logic [lwfd_pkg::ID_W-1:0]   thread_id;
  logic [lwfd_pkg::ID_W-1:0]   lock_id;
  modport source (output valid, mode, thread_id, lock_id, input ready);
  modport sink   (input valid, mode, thread_id, lock_id, output ready);
endinterface

interface lwfd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lwfd_pkg::STATUS_W-1:0] status;
  logic [lwfd_pkg::ID_W-1:0]     owner_thread;
  logic                          deadlock_now;
  logic                          deadlock_seen;
  logic [lwfd_pkg::ID_W-1:0]     cycle_thread;
  modport source (output valid, status, owner_thread, deadlock_now, deadlock_seen,
                  cycle_thread, input ready);
  modport sink   (input valid, status, owner_thread, deadlock_now, deadlock_seen,
                  cycle_thread, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lwfd_ram.sv =====
// Single write port, single registered read port RAM
`default_nettype none
module lwfd_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/lock_wait_for_deadlock_detector_core.sv =====
// Lock owner table, wait-for matrix and cycle check under one sequencer
// Request/acquire walk the owner table, then the vertex table when the lock has a holder;
// release walks only the owner table; register the vertex table; check the reach matrix.
// Throughput: one beat at a time; the single RAM read port of each table sets the pace.
// Reset: synchronous; a clearing pass follows, during which no beat is accepted.
// Owner and wait tables clear, sticky flag and vertex count go to zero.
`default_nettype none
module lock_wait_for_deadlock_detector_core #(
  parameter int OWNER_SLOTS = 64,
  parameter int VERTICES    = 32
) (
  input wire logic clk,
  input wire logic rst,
  lwfd_req_if.sink   req,
  lwfd_rsp_if.source rsp
);

  localparam int SW    = $clog2(OWNER_SLOTS);
  localparam int VW    = $clog2(VERTICES);
  localparam int VC_W  = $clog2(VERTICES + 1);
  localparam int MAXD  = (OWNER_SLOTS > VERTICES) ? OWNER_SLOTS : VERTICES;
  localparam int CNT_W = $clog2(MAXD + 1);
  localparam int IW    = lwfd_pkg::ID_W;

  lwfd_pkg::state_t state, state_next;

  logic [CNT_W-1:0] cnt, prv;
  logic [SW-1:0]    prv_s;
  logic [VW-1:0]    prv_v;

  logic [lwfd_pkg::MODE_W-1:0]   mode_r;
  logic [IW-1:0]                 tid_r, lock_r, owner_r, cyc_r;
  logic [lwfd_pkg::STATUS_W-1:0] status_r;
  logic                          now_r, sticky;
  logic                          own_found, free_found, rel_found, ft_found, fo_found;
  logic [SW-1:0]                 free_idx, rel_idx;
  logic [VW-1:0]                 ft_idx, fo_idx, f_idx, t_idx, k, cyc_idx;
  logic [VERTICES-1:0]           rk;
  logic [VC_W-1:0]               vcount;

  // RAM ports
  logic                 o_we;
  logic [SW-1:0]        o_waddr, o_raddr;
  logic [2*IW-1:0]      o_wdata, o_rdata;
  logic                 v_we;
  logic [VW-1:0]        v_waddr, v_raddr;
  logic [IW-1:0]        v_wdata, v_rdata;
  logic                 w_we;
  logic [VW-1:0]        w_waddr, w_raddr;
  logic [VERTICES-1:0]  w_wdata, w_rdata;
  logic                 r_we;
  logic [VW-1:0]        r_waddr, r_raddr;
  logic [VERTICES-1:0]  r_wdata, r_rdata;

  logic                 vroom, t_ok, last_k, slot_used;
  logic [VERTICES-1:0]  t_bit;
  logic [CNT_W-1:0]     n_cnt;

  lwfd_ram #(.DEPTH(OWNER_SLOTS), .WIDTH(2*IW)) u_owner (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr), .rdata(o_rdata));
  lwfd_ram #(.DEPTH(VERTICES), .WIDTH(IW)) u_vertex (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rdata));
  lwfd_ram #(.DEPTH(VERTICES), .WIDTH(VERTICES)) u_wait (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rdata));
  lwfd_ram #(.DEPTH(VERTICES), .WIDTH(VERTICES)) u_reach (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r_rdata));

  // Shared decode
  always_comb begin
    prv       = cnt - 1'b1;
    prv_s     = prv[SW-1:0];
    prv_v     = prv[VW-1:0];
    n_cnt     = CNT_W'(vcount);
    vroom     = vcount < VC_W'(VERTICES);
    t_ok      = (owner_r == tid_r) || fo_found || vroom;
    last_k    = (VC_W'(k) + 1'b1) >= vcount;
    slot_used = o_rdata != '0;
    t_bit     = VERTICES'(1) << t_idx;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lwfd_pkg::ST_CLEAR: if (cnt == CNT_W'(MAXD - 1)) state_next = lwfd_pkg::ST_IDLE;
      lwfd_pkg::ST_IDLE: begin
        if (req.valid) begin
          case (req.mode)
            lwfd_pkg::MODE_REQUEST, lwfd_pkg::MODE_ACQUIRE, lwfd_pkg::MODE_RELEASE:
              state_next = lwfd_pkg::ST_OSCAN;
            lwfd_pkg::MODE_REGISTER:
              state_next = (req.thread_id != '0) ? lwfd_pkg::ST_VSCAN : lwfd_pkg::ST_DONE;
            lwfd_pkg::MODE_CHECK:
              state_next = (vcount != '0) ? lwfd_pkg::ST_COPY : lwfd_pkg::ST_DONE;
            default: state_next = lwfd_pkg::ST_DONE;
          endcase
        end
      end
      lwfd_pkg::ST_OSCAN: if (cnt == CNT_W'(OWNER_SLOTS)) state_next = lwfd_pkg::ST_ODEC;
      lwfd_pkg::ST_ODEC: begin
        if (mode_r == lwfd_pkg::MODE_RELEASE) begin
          state_next = lwfd_pkg::ST_OWRITE;
        end else if (tid_r != '0 && owner_r != '0) begin
          state_next = lwfd_pkg::ST_VSCAN;
        end else if (mode_r == lwfd_pkg::MODE_ACQUIRE) begin
          state_next = lwfd_pkg::ST_OWRITE;
        end else begin
          state_next = lwfd_pkg::ST_DONE;
        end
      end
      lwfd_pkg::ST_VSCAN: if (cnt == n_cnt) state_next = lwfd_pkg::ST_VADD1;
      lwfd_pkg::ST_VADD1: begin
        if (mode_r == lwfd_pkg::MODE_REGISTER) begin
          state_next = lwfd_pkg::ST_DONE;
        end else if (mode_r == lwfd_pkg::MODE_ACQUIRE) begin
          state_next = (ft_found && fo_found) ? lwfd_pkg::ST_ROWRD : lwfd_pkg::ST_OWRITE;
        end else begin
          state_next = (ft_found || vroom) ? lwfd_pkg::ST_VADD2 : lwfd_pkg::ST_DONE;
        end
      end
      lwfd_pkg::ST_VADD2: state_next = t_ok ? lwfd_pkg::ST_ROWRD : lwfd_pkg::ST_DONE;
      lwfd_pkg::ST_ROWRD: state_next = lwfd_pkg::ST_ROWWR;
      lwfd_pkg::ST_ROWWR:
        state_next = (mode_r == lwfd_pkg::MODE_ACQUIRE) ? lwfd_pkg::ST_OWRITE : lwfd_pkg::ST_DONE;
      lwfd_pkg::ST_OWRITE: state_next = lwfd_pkg::ST_DONE;
      lwfd_pkg::ST_COPY: if (cnt == n_cnt) state_next = lwfd_pkg::ST_KRD;
      lwfd_pkg::ST_KRD: state_next = lwfd_pkg::ST_KPASS;
      lwfd_pkg::ST_KPASS:
        if (cnt == n_cnt) state_next = last_k ? lwfd_pkg::ST_FSCAN : lwfd_pkg::ST_KRD;
      lwfd_pkg::ST_FSCAN: begin
        if (cnt != '0 && r_rdata[prv_v]) begin
          state_next = lwfd_pkg::ST_VRD;
        end else if (cnt == n_cnt) begin
          state_next = lwfd_pkg::ST_DONE;
        end
      end
      lwfd_pkg::ST_VRD: state_next = lwfd_pkg::ST_VWR;
      lwfd_pkg::ST_VWR: state_next = lwfd_pkg::ST_DONE;
      lwfd_pkg::ST_DONE: if (rsp.ready) state_next = lwfd_pkg::ST_IDLE;
      default: state_next = lwfd_pkg::ST_CLEAR;
    endcase
  end

  // Memory control and handshake outputs
  always_comb begin
    o_we    = 1'b0;
    o_waddr = cnt[SW-1:0];
    o_wdata = '0;
    o_raddr = cnt[SW-1:0];
    v_we    = 1'b0;
    v_waddr = vcount[VW-1:0];
    v_wdata = tid_r;
    v_raddr = (state == lwfd_pkg::ST_VRD) ? cyc_idx : cnt[VW-1:0];
    w_we    = 1'b0;
    w_waddr = cnt[VW-1:0];
    w_wdata = '0;
    w_raddr = (state == lwfd_pkg::ST_ROWRD) ? f_idx : cnt[VW-1:0];
    r_we    = 1'b0;
    r_waddr = prv_v;
    r_wdata = w_rdata;
    r_raddr = (state == lwfd_pkg::ST_KRD) ? k : cnt[VW-1:0];
    case (state)
      lwfd_pkg::ST_CLEAR: begin
        o_we = cnt < CNT_W'(OWNER_SLOTS);
        w_we = cnt < CNT_W'(VERTICES);
      end
      lwfd_pkg::ST_VADD1:
        v_we = (mode_r != lwfd_pkg::MODE_ACQUIRE) && !ft_found && vroom;
      lwfd_pkg::ST_VADD2: begin
        v_we    = (owner_r != tid_r) && !fo_found && vroom;
        v_wdata = owner_r;
      end
      lwfd_pkg::ST_ROWWR: begin
        w_we    = 1'b1;
        w_waddr = f_idx;
        w_wdata = (mode_r == lwfd_pkg::MODE_ACQUIRE) ? (w_rdata & ~t_bit) : (w_rdata | t_bit);
      end
      lwfd_pkg::ST_OWRITE: begin
        if (mode_r == lwfd_pkg::MODE_ACQUIRE) begin
          o_we    = free_found;
          o_waddr = free_idx;
          o_wdata = {lock_r, tid_r};
        end else begin
          o_we    = rel_found;
          o_waddr = rel_idx;
        end
      end
      lwfd_pkg::ST_COPY: r_we = cnt != '0;
      lwfd_pkg::ST_KPASS: begin
        r_we    = (cnt != '0) && r_rdata[k];
        r_wdata = r_rdata | rk;
      end
      default: ;
    endcase
  end

  assign req.ready         = state == lwfd_pkg::ST_IDLE;
  assign rsp.valid         = state == lwfd_pkg::ST_DONE;
  assign rsp.status        = status_r;
  assign rsp.owner_thread  = owner_r;
  assign rsp.deadlock_now  = now_r;
  assign rsp.deadlock_seen = sticky;
  assign rsp.cycle_thread  = cyc_r;

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lwfd_pkg::ST_CLEAR;
      cnt    <= '0;
      vcount <= '0;
      sticky <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + 1'b1;
      case (state)
        // Latch the beat and drop the search flags
        lwfd_pkg::ST_IDLE: begin
          mode_r     <= req.mode;
          tid_r      <= req.thread_id;
          lock_r     <= req.lock_id;
          owner_r    <= '0;
          cyc_r      <= '0;
          now_r      <= 1'b0;
          status_r   <= lwfd_pkg::STATUS_OK;
          own_found  <= 1'b0;
          free_found <= 1'b0;
          rel_found  <= 1'b0;
          ft_found   <= 1'b0;
          fo_found   <= 1'b0;
          k          <= '0;
        end
        // Walk the owner table: holder, first free slot, matching slot
        lwfd_pkg::ST_OSCAN: begin
          if (cnt != '0) begin
            if (slot_used && o_rdata[2*IW-1:IW] == lock_r && !own_found) begin
              own_found <= 1'b1;
              owner_r   <= o_rdata[IW-1:0];
            end
            if (!slot_used && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= prv_s;
            end
            if (slot_used && o_rdata == {lock_r, tid_r} && !rel_found) begin
              rel_found <= 1'b1;
              rel_idx   <= prv_s;
            end
          end
        end
        // Walk the vertex table for both ends of the edge
        lwfd_pkg::ST_VSCAN: begin
          if (cnt != '0) begin
            if (v_rdata == tid_r && !ft_found) begin
              ft_found <= 1'b1;
              ft_idx   <= prv_v;
            end
            if (v_rdata == owner_r && !fo_found) begin
              fo_found <= 1'b1;
              fo_idx   <= prv_v;
            end
          end
        end
        lwfd_pkg::ST_VADD1: begin
          t_idx <= fo_idx;
          if (ft_found) begin
            f_idx <= ft_idx;
          end else if (mode_r != lwfd_pkg::MODE_ACQUIRE) begin
            if (vroom) begin
              f_idx  <= vcount[VW-1:0];
              vcount <= vcount + 1'b1;
            end else begin
              status_r <= lwfd_pkg::STATUS_VERT_FULL;
            end
          end
        end
        lwfd_pkg::ST_VADD2: begin
          if (owner_r == tid_r) begin
            t_idx <= f_idx;
          end else if (fo_found) begin
            t_idx <= fo_idx;
          end else if (vroom) begin
            t_idx  <= vcount[VW-1:0];
            vcount <= vcount + 1'b1;
          end else begin
            status_r <= lwfd_pkg::STATUS_VERT_FULL;
          end
        end
        lwfd_pkg::ST_OWRITE: begin
          if (mode_r == lwfd_pkg::MODE_ACQUIRE) begin
            status_r <= free_found ? lwfd_pkg::STATUS_OK : lwfd_pkg::STATUS_OWNER_FULL;
          end else begin
            status_r <= rel_found ? lwfd_pkg::STATUS_OK : lwfd_pkg::STATUS_NOT_FOUND;
          end
        end
        // Hold pivot row, advance pivot after each pass
        lwfd_pkg::ST_KPASS: begin
          if (cnt == '0) rk <= r_rdata;
          if (cnt == n_cnt) k <= k + 1'b1;
        end
        lwfd_pkg::ST_FSCAN: if (cnt != '0 && r_rdata[prv_v]) cyc_idx <= prv_v;
        lwfd_pkg::ST_VWR: begin
          cyc_r  <= v_rdata;
          now_r  <= 1'b1;
          sticky <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
